FILE: sv/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared constants, command codes and control/status types for the
// indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = 11;
	localparam int CMD_W    = 3;
	localparam int DATA_W   = 32;
	localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

	typedef struct packed {
		logic load;          // capture the incoming transaction
		logic ptr_init_cnt;
		logic ptr_init_idx;
		logic step_dn;       // insert shift step
		logic step_up;       // remove shift step
		logic rd_at_idx;
		logic wr_at_cnt;
		logic wr_at_idx;
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_clr;
		logic res_load;      // ok <= res_ok, value <= 0
		logic res_ok;
		logic val_cap;       // ok <= 1, value <= read data
		logic out_load;
	} ils_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             idx_lt_cnt;
		logic             idx_le_cnt;
		logic             full;
		logic             more_dn;
		logic             more_up;
		logic             pend;
	} ils_sts_t;

endpackage

FILE: sv/ils_dp.sv
// ----------------------------------------------------------------------------
// ils_dp
// Datapath: entry memory, element count, shift pointer and result registers.
// ----------------------------------------------------------------------------
module ils_dp import ils_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [IDX_W-1:0]         index,
	input  logic signed [DATA_W-1:0] data,
	input  ils_ctl_t                 ctl,
	output ils_sts_t                 sts,
	output logic                     ok,
	output logic signed [DATA_W-1:0] value,
	output logic [IDX_W-1:0]         count
);

	logic [DATA_W-1:0] mem [CAPACITY];

	logic [CMD_W-1:0]  cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic              pend_q;
	logic [DATA_W-1:0] rdata_q;
	logic              ok_q;
	logic [DATA_W-1:0] value_q;
	logic              ok_out_q;
	logic [DATA_W-1:0] value_out_q;
	logic [IDX_W-1:0]  count_out_q;

	logic [CMP_W-1:0]  idx_ext;
	logic [CMP_W-1:0]  cnt_ext;
	logic [CMP_W-1:0]  ptr_ext;
	logic [ADDR_W-1:0] idx_addr;
	logic [CNT_W-1:0]  ptr_nxt;
	logic              more_dn;
	logic              more_up;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	assign idx_ext  = CMP_W'(idx_q);
	assign cnt_ext  = CMP_W'(cnt_q);
	assign ptr_ext  = CMP_W'(ptr_q);
	assign idx_addr = idx_ext[ADDR_W-1:0];
	assign ptr_nxt  = CNT_W'(ptr_q) + CNT_W'(1);
	assign more_dn  = ptr_ext > idx_ext;
	assign more_up  = ptr_nxt < cnt_q;

	assign sts.cmd        = cmd_q;
	assign sts.idx_lt_cnt = idx_ext < cnt_ext;
	assign sts.idx_le_cnt = idx_ext <= cnt_ext;
	assign sts.full       = cnt_q == CNT_W'(CAPACITY);
	assign sts.more_dn    = more_dn;
	assign sts.more_up    = more_up;
	assign sts.pend       = pend_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_addr;
		if (ctl.rd_at_idx) begin
			rd_en   = 1'b1;
			rd_addr = idx_addr;
		end else if (ctl.step_dn && more_dn) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q - ADDR_W'(1);
		end else if (ctl.step_up && more_up) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q + ADDR_W'(1);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_addr_q;
		wr_data = rdata_q;
		if (pend_q) begin
			wr_en = 1'b1;
		end else if (ctl.wr_at_cnt) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[ADDR_W-1:0];
			wr_data = data_q;
		end else if (ctl.wr_at_idx) begin
			wr_en   = 1'b1;
			wr_addr = idx_addr;
			wr_data = data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			idx_q  <= index;
			data_q <= data;
		end
		if (ctl.ptr_init_cnt) begin
			ptr_q <= cnt_q[ADDR_W-1:0];
		end else if (ctl.ptr_init_idx) begin
			ptr_q <= idx_addr;
		end else if (ctl.step_dn && more_dn) begin
			ptr_q     <= ptr_q - ADDR_W'(1);
			wr_addr_q <= ptr_q;
		end else if (ctl.step_up && more_up) begin
			ptr_q     <= ptr_q + ADDR_W'(1);
			wr_addr_q <= ptr_q;
		end
		if (ctl.val_cap) begin
			ok_q    <= 1'b1;
			value_q <= rdata_q;
		end else if (ctl.res_load) begin
			ok_q    <= ctl.res_ok;
			value_q <= '0;
		end
		if (ctl.out_load) begin
			ok_out_q    <= ok_q;
			value_out_q <= value_q;
			count_out_q <= cnt_ext[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= (ctl.step_dn && more_dn) || (ctl.step_up && more_up);
			if (ctl.cnt_clr) begin
				cnt_q <= '0;
			end else if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (ctl.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign ok    = ok_out_q;
	assign value = value_out_q;
	assign count = count_out_q;

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({pend_q, ctl.wr_at_cnt, ctl.wr_at_idx}))
		else $error("memory write port driven by more than one source");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

endmodule

FILE: sv/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Controller: sequences one transaction at a time through decode, memory
// read, shift loop and result hand-off.
// ----------------------------------------------------------------------------
module ils_ctrl import ils_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  ils_sts_t sts,
	output ils_ctl_t ctl
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_RDWAIT = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_INSWR  = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		ctl.load = in_valid && !in_stall;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d      = ST_FIN;
				ctl.res_load = 1'b1;
				case (sts.cmd)
					CMD_APPEND: begin
						if (!sts.full) begin
							ctl.wr_at_cnt = 1'b1;
							ctl.cnt_inc   = 1'b1;
							ctl.res_ok    = 1'b1;
						end
					end
					CMD_READ: begin
						if (sts.idx_lt_cnt) begin
							ctl.rd_at_idx = 1'b1;
							state_d       = ST_RDWAIT;
						end
					end
					CMD_INSERT: begin
						if (sts.idx_le_cnt && !sts.full) begin
							ctl.ptr_init_cnt = 1'b1;
							state_d          = ST_SHIFT;
						end
					end
					CMD_REMOVE: begin
						if (sts.idx_lt_cnt) begin
							ctl.rd_at_idx    = 1'b1;
							ctl.ptr_init_idx = 1'b1;
							state_d          = ST_RDWAIT;
						end
					end
					CMD_WRITE: begin
						if (sts.idx_lt_cnt) begin
							ctl.wr_at_idx = 1'b1;
							ctl.res_ok    = 1'b1;
						end
					end
					CMD_CLEAR: begin
						ctl.cnt_clr = 1'b1;
						ctl.res_ok  = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_RDWAIT: begin
				ctl.val_cap = 1'b1;
				state_d     = (sts.cmd == CMD_REMOVE) ? ST_SHIFT : ST_FIN;
			end
			ST_SHIFT: begin
				if (sts.cmd == CMD_INSERT) begin
					ctl.step_dn = 1'b1;
					if (!sts.more_dn && !sts.pend) begin
						state_d = ST_INSWR;
					end
				end else begin
					ctl.step_up = 1'b1;
					if (!sts.more_up && !sts.pend) begin
						ctl.cnt_dec = 1'b1;
						state_d     = ST_FIN;
					end
				end
			end
			ST_INSWR: begin
				ctl.wr_at_idx = 1'b1;
				ctl.cnt_inc   = 1'b1;
				ctl.res_load  = 1'b1;
				ctl.res_ok    = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == ST_DECODE)
		else $error("accepted transaction not decoded next cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> out_free)
		else $error("result register loaded while still held");

endmodule

FILE: sv/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit words with append, read, insert, remove,
// overwrite and clear transactions, one result per transaction.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. Insert and remove move entries one
// per cycle through the single read and single write port of the CAPACITY x
// 32 entry memory, and the last move drains before the final write. A
// finished result sits in an output register, so the next transaction is
// accepted while it waits to be taken. The memory needs no clearing after
// reset; only entries below the count are ever read.
module indexed_list_store import ils_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [IDX_W-1:0]         index,
	input  logic signed [DATA_W-1:0] data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic signed [DATA_W-1:0] value,
	output logic [IDX_W-1:0]         count
);

	ils_ctl_t ctl;
	ils_sts_t sts;

	ils_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	ils_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.index  (index),
		.data   (data),
		.ctl    (ctl),
		.sts    (sts),
		.ok     (ok),
		.value  (value),
		.count  (count)
	);

endmodule

FILE: tb/indexed_list_store_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_store_test
// Self-checking testbench for the indexed list store. A shadow copy of the
// list predicts ok, value and count for every accepted command, and each
// result taken from the block is compared against the oldest prediction.
// Directed edge cases, a full-store pass, an output hold-off that fills the
// block, and a long random mix run with random idling on both channels.
// ----------------------------------------------------------------------------
module indexed_list_store_test;
	import ils_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 400;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         count;
	} list_result_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	logic [CMD_W-1:0]         cmd       = '0;
	logic [IDX_W-1:0]         index     = '0;
	logic signed [DATA_W-1:0] data      = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     ok;
	logic signed [DATA_W-1:0] value;
	logic [IDX_W-1:0]         count;

	logic [DATA_W-1:0] shadow_entries [CAPACITY];
	int                shadow_count = 0;
	list_result_t      expected_results [$];

	bit no_idle         = 1'b0;
	int hold_len        = 0;
	int rx_stall_left   = 0;
	int rx_gap          = 0;
	int idle_cycles     = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int error_count     = 0;

	indexed_list_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.index    (index),
		.data     (data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok       (ok),
		.value    (value),
		.count    (count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// apply one command to the shadow list and queue the expected result
	function automatic void apply_to_shadow(logic [CMD_W-1:0] op, logic [IDX_W-1:0] pos,
			logic [DATA_W-1:0] word);
		list_result_t r;
		int           j;
		r = '0;
		case (op)
		CMD_APPEND: begin
			if (shadow_count < CAPACITY) begin
				shadow_entries[shadow_count] = word;
				shadow_count++;
				r.ok = 1'b1;
			end
		end
		CMD_READ: begin
			if (pos < shadow_count) begin
				r.value = shadow_entries[pos];
				r.ok    = 1'b1;
			end
		end
		CMD_INSERT: begin
			if (pos <= shadow_count && shadow_count < CAPACITY) begin
				for (j = shadow_count; j > pos; j--)
					shadow_entries[j] = shadow_entries[j-1];
				shadow_entries[pos] = word;
				shadow_count++;
				r.ok = 1'b1;
			end
		end
		CMD_REMOVE: begin
			if (pos < shadow_count) begin
				r.value = shadow_entries[pos];
				for (j = pos; j + 1 < shadow_count; j++)
					shadow_entries[j] = shadow_entries[j+1];
				shadow_count--;
				r.ok = 1'b1;
			end
		end
		CMD_WRITE: begin
			if (pos < shadow_count) begin
				shadow_entries[pos] = word;
				r.ok = 1'b1;
			end
		end
		CMD_CLEAR: begin
			shadow_count = 0;
			r.ok = 1'b1;
		end
		default: ;
		endcase
		r.count = shadow_count[IDX_W-1:0];
		expected_results.push_back(r);
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return '0;
		3: return '1;
		default: return $urandom();
		endcase
	endfunction

	task automatic send_command(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] pos,
			input logic [DATA_W-1:0] word);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		index    <= pos;
		data     <= word;
		do @(posedge clk); while (in_stall);
		apply_to_shadow(op, pos, word);
		items_sent++;
	endtask

	// mostly well-formed list operations on a short list, some bad indexes and noise
	task automatic send_random_op();
		logic [CMD_W-1:0] op;
		logic [IDX_W-1:0] pos;
		int               pick;
		bit               good;
		pick = $urandom_range(0, 99);
		good = ($urandom_range(0, 99) < 85);
		if (pick < 3) begin
			send_command(CMD_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, CAPACITY)),
				rand_word());
		end else if (pick < 6) begin
			send_command(CMD_CLEAR, IDX_W'($urandom_range(0, CAPACITY)), rand_word());
		end else begin
			case ($urandom_range(0, 4))
			0: op = CMD_APPEND;
			1: op = CMD_READ;
			2: op = CMD_INSERT;
			3: op = CMD_REMOVE;
			default: op = CMD_WRITE;
			endcase
			if (shadow_count > 48 && (op == CMD_APPEND || op == CMD_INSERT))
				op = CMD_REMOVE;
			if (op == CMD_INSERT)
				pos = good ? IDX_W'($urandom_range(0, shadow_count))
				           : IDX_W'($urandom_range(shadow_count + 1, CAPACITY));
			else if (good && shadow_count > 0)
				pos = IDX_W'($urandom_range(0, shadow_count - 1));
			else
				pos = IDX_W'($urandom_range(shadow_count, CAPACITY));
			send_command(op, pos, rand_word());
		end
	endtask

	// result side: check, then stall for a random gap or a requested hold
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: ok=%0b value=%0d count=%0d", ok, value, count);
				error_count++;
			end else begin
				list_result_t exp_r;
				exp_r = expected_results.pop_front();
				if (ok !== exp_r.ok) begin
					$error("ok: expected %0b, got %0b", exp_r.ok, ok);
					error_count++;
				end
				if (value !== exp_r.value) begin
					$error("value: expected %0d, got %0d", exp_r.value, value);
					error_count++;
				end
				if (count !== exp_r.count) begin
					$error("count: expected %0d, got %0d", exp_r.count, count);
					error_count++;
				end
			end
			results_checked++;
			rx_gap = no_idle ? 0 : $urandom_range(0, 19);
			if (hold_len != 0) begin
				rx_gap   = hold_len;
				hold_len = 0;
			end
			if (rx_gap != 0) begin
				out_stall <= 1'b1;
				rx_stall_left = rx_gap;
			end
		end else if (out_stall) begin
			rx_stall_left--;
			if (rx_stall_left <= 0)
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_directed_edges();
		send_command(CMD_APPEND, 0, 32'h8000_0000);
		send_command(CMD_APPEND, 0, 32'h7FFF_FFFF);
		send_command(CMD_APPEND, IDX_W'(CAPACITY), 32'h0000_0000);
		send_command(CMD_READ, 0, '0);
		send_command(CMD_READ, 2, '1);
		send_command(CMD_READ, 3, '0);
		send_command(CMD_INSERT, 0, 32'hFFFF_FFFF);
		send_command(CMD_INSERT, 2, 32'h5555_5555);
		send_command(CMD_INSERT, 5, 32'hAAAA_AAAA);
		send_command(CMD_INSERT, 7, 32'h1111_1111);
		send_command(CMD_WRITE, 1, 32'h1234_5678);
		send_command(CMD_WRITE, 6, 32'h8765_4321);
		send_command(CMD_REMOVE, 0, '0);
		send_command(CMD_REMOVE, 4, '0);
		send_command(CMD_REMOVE, 4, '0);
		send_command(CMD_READ, IDX_W'(CAPACITY), '0);
		send_command(CMD_SPARE6, 1, 32'hDEAD_BEEF);
		send_command(CMD_SPARE7, 0, 32'h0BAD_F00D);
		send_command(CMD_READ, 1, '0);
		send_command(CMD_CLEAR, 3, '1);
		send_command(CMD_READ, 0, '0);
		send_command(CMD_REMOVE, 0, '0);
		send_command(CMD_WRITE, 0, 32'h7777_7777);
		send_command(CMD_APPEND, 0, 32'h0F0F_0F0F);
		send_command(CMD_READ, 0, '0);
	endtask

	task automatic test_full_store();
		no_idle = 1'b1;
		while (shadow_count < CAPACITY / 2)
			send_command(CMD_APPEND, IDX_W'($urandom_range(0, CAPACITY)), rand_word());
		no_idle = 1'b0;
		while (shadow_count < CAPACITY)
			send_command(CMD_APPEND, IDX_W'($urandom_range(0, CAPACITY)), rand_word());
		send_command(CMD_APPEND, 0, rand_word());
		send_command(CMD_INSERT, IDX_W'(CAPACITY), rand_word());
		send_command(CMD_INSERT, 0, rand_word());
		send_command(CMD_READ, IDX_W'(CAPACITY - 1), '0);
		send_command(CMD_READ, IDX_W'(CAPACITY), '0);
		send_command(CMD_WRITE, IDX_W'(CAPACITY - 1), rand_word());
		send_command(CMD_REMOVE, 0, '0);
		send_command(CMD_INSERT, 0, rand_word());
		send_command(CMD_REMOVE, IDX_W'(CAPACITY - 1), '0);
		send_command(CMD_INSERT, IDX_W'(CAPACITY - 1), rand_word());
		send_command(CMD_READ, IDX_W'(CAPACITY - 1), '0);
		send_command(CMD_READ, 0, '0);
		send_command(CMD_CLEAR, 0, '0);
	endtask

	task automatic test_backpressure();
		no_idle  = 1'b1;
		hold_len = HOLD_CYCLES;
		repeat (20) send_random_op();
		no_idle = 1'b0;
	endtask

	task automatic test_random_ops();
		int i;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			send_random_op();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_full_store();
		test_backpressure();
		test_random_ops();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		$display("Covered %0d transactions: edge cases, full store, output hold-off, random mix.",
			items_sent);
		$display("Checked %0d results against the shadow list, %0d mismatches.",
			results_checked, error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
